@@ sv/l2l4hp_pkg.sv @@
package l2l4hp_pkg;

  // Default build-time values.
  localparam int ICMP_HEADER_BYTES_DEF = 8;
  localparam int COUNT_BITS_DEF        = 16;
  localparam int QUEUE_DEPTH_DEF       = 2;

  // Width of the frame length carried from the front to the back.
  localparam int LEN_BITS = 16;

  // Header layout constants.
  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_TYPE_IPV6 = 16'h86DD;
  localparam logic [7:0]  PROTO_ICMPV4  = 8'd1;
  localparam logic [7:0]  PROTO_TCP     = 8'd6;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;
  localparam logic [7:0]  PROTO_ICMPV6  = 8'd58;

  localparam int ETH_LEN      = 14;
  localparam int IPV4_MIN_LEN = 20;
  localparam int IPV6_LEN     = 40;
  localparam int TCP_LEN      = 20;
  localparam int UDP_LEN      = 8;

  // Byte offsets inside the frame.
  localparam int OFS_TYPE_HI   = 12;
  localparam int OFS_TYPE_LO   = 13;
  localparam int OFS_IHL       = 14;
  localparam int OFS_V6_NEXT   = 20;
  localparam int OFS_V6_HOPS   = 21;
  localparam int OFS_V4_TTL    = 22;
  localparam int OFS_V4_PROTO  = 23;
  localparam int OFS_SRC_FIRST = 26;
  localparam int OFS_SRC_LAST  = 29;
  localparam int OFS_DST_FIRST = 30;
  localparam int OFS_DST_LAST  = 33;
  localparam int OFS_V6_L4     = ETH_LEN + IPV6_LEN;

  // Layer kind codes.
  localparam logic [1:0] L3_NONE = 2'd0;
  localparam logic [1:0] L3_IPV4 = 2'd1;
  localparam logic [1:0] L3_IPV6 = 2'd2;

  localparam logic [1:0] ICMP_NONE = 2'd0;
  localparam logic [1:0] ICMP_V4   = 2'd1;
  localparam logic [1:0] ICMP_V6   = 2'd2;

  // One input beat.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } hdr_in_t;

  // One parsed record.
  typedef struct packed {
    logic [15:0] eth_type;
    logic [1:0]  l3_kind;
    logic [7:0]  next_protocol;
    logic [7:0]  hop_limit;
    logic [31:0] source_ipv4;
    logic [31:0] dest_ipv4;
    logic        has_ports;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [1:0]  icmp_kind;
    logic [7:0]  icmp_msg_type;
    logic [7:0]  icmp_msg_code;
  } hdr_out_t;

  // Raw fields latched by the front for one frame, not yet classified.
  typedef struct packed {
    logic [LEN_BITS-1:0] frame_len;
    logic [15:0]         eth_type;
    logic [3:0]          header_words;
    logic [7:0]          proto;
    logic [7:0]          hops;
    logic [31:0]         src_addr;
    logic [31:0]         dst_addr;
    logic [31:0]         port_pair;
    logic [15:0]         icmp_pair;
  } raw_rec_t;

  // Handshake between the queue and its neighbors.
  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ sv/l2_l4_packet_header_parser.sv @@
// Layer 2 to layer 4 header parser.
//
// Input channel: one captured frame byte per beat in wire order, with
// last_byte set on the final byte. A beat is taken when in_push is high and
// in_full is low. Bytes are taken one per clock while not full, no frame gaps.
// Result channel: one parsed record per frame (EtherType, IPv4/IPv6 kind,
// protocol, hop limit, IPv4 addresses, TCP/UDP ports, ICMP type and code),
// shown while out_empty is low and taken when out_pop is high.
// The record passes through the record queue and the output register before
// it is shown. Throughput: one byte per cycle while in_full is low; a one-byte
// frame every cycle is sustained while results are popped each cycle.
// The front counts bytes and latches fields; a two-entry record queue and an
// output register separate it from the back, which classifies each record.
// When the receiver stalls, the queue fills and in_full rises once two
// records wait behind the held result; no byte or record is lost.
// Reset (synchronous, active low) clears the byte count, the partial frame
// and all queued results.
module l2_l4_packet_header_parser #(
  parameter int ICMP_HEADER_BYTES = l2l4hp_pkg::ICMP_HEADER_BYTES_DEF,
  parameter int COUNT_BITS        = l2l4hp_pkg::COUNT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  l2l4hp_pkg::hdr_in_t  in_data,
  output logic                 out_empty,
  input  logic                 out_pop,
  output l2l4hp_pkg::hdr_out_t out_data
);
  import l2l4hp_pkg::*;

  logic     beat_take;
  logic     rec_push;
  logic     rec_take;
  raw_rec_t front_rec;
  raw_rec_t head_rec;
  q_ctrl_t  q_ctrl;
  q_stat_t  q_stat;

  assign in_full   = q_stat.full;
  assign beat_take = in_push && !q_stat.full;

  // Byte counting and field capture.
  l2l4hp_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .beat_take(beat_take),
    .beat     (in_data),
    .rec_push (rec_push),
    .rec      (front_rec)
  );

  // Short record queue between front and back.
  assign q_ctrl.push = rec_push;
  assign q_ctrl.pop  = rec_take;

  l2l4hp_queue #(
    .DEPTH(QUEUE_DEPTH_DEF)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (q_ctrl),
    .wr_rec(front_rec),
    .stat  (q_stat),
    .rd_rec(head_rec)
  );

  // Classification and result register.
  l2l4hp_back #(
    .ICMP_HEADER_BYTES(ICMP_HEADER_BYTES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .rec      (head_rec),
    .rec_avail(!q_stat.empty),
    .rec_take (rec_take),
    .res_pop  (out_pop),
    .res_empty(out_empty),
    .res      (out_data)
  );

endmodule

@@ sv/l2l4hp_front.sv @@
module l2l4hp_front #(
  parameter int COUNT_BITS = l2l4hp_pkg::COUNT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 beat_take,
  input  l2l4hp_pkg::hdr_in_t  beat,
  output logic                 rec_push,
  output l2l4hp_pkg::raw_rec_t rec
);
  import l2l4hp_pkg::*;

  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [15:0]           type_r, type_nxt;
  logic [3:0]            words_r, words_nxt;
  logic [7:0]            proto_r, proto_nxt;
  logic [7:0]            hops_r, hops_nxt;
  logic [31:0]           src_r, src_nxt;
  logic [31:0]           dst_r, dst_nxt;
  logic [31:0]           ports_r, ports_nxt;
  logic [15:0]           icmp_r, icmp_nxt;

  logic [COUNT_BITS-1:0] pos;
  logic [COUNT_BITS-1:0] l4_start;
  logic [COUNT_BITS-1:0] l4_ofs;
  logic [6:0]            l4_start_small;
  logic [3:0]            words_now;
  logic                  live;
  logic                  in_l4;
  logic [7:0]            b;

  assign pos  = cnt_r;
  assign b    = beat.data_byte;
  assign live = (cnt_r != '1);

  // Latch header fields as their offsets pass.
  always_comb begin
    type_nxt  = type_r;
    words_nxt = words_r;
    proto_nxt = proto_r;
    hops_nxt  = hops_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    ports_nxt = ports_r;
    icmp_nxt  = icmp_r;
    cnt_nxt   = cnt_r;
    if (live) begin
      if (pos == COUNT_BITS'(OFS_TYPE_HI)) type_nxt[15:8] = b;
      if (pos == COUNT_BITS'(OFS_TYPE_LO)) type_nxt[7:0] = b;
      if (pos == COUNT_BITS'(OFS_IHL)) words_nxt = b[3:0];
      if (type_nxt == ETH_TYPE_IPV4) begin
        if (pos == COUNT_BITS'(OFS_V4_TTL)) hops_nxt = b;
        if (pos == COUNT_BITS'(OFS_V4_PROTO)) proto_nxt = b;
      end else if (type_nxt == ETH_TYPE_IPV6) begin
        if (pos == COUNT_BITS'(OFS_V6_NEXT)) proto_nxt = b;
        if (pos == COUNT_BITS'(OFS_V6_HOPS)) hops_nxt = b;
      end
      if (pos >= COUNT_BITS'(OFS_SRC_FIRST) && pos <= COUNT_BITS'(OFS_SRC_LAST)) begin
        src_nxt = {src_r[23:0], b};
      end
      if (pos >= COUNT_BITS'(OFS_DST_FIRST) && pos <= COUNT_BITS'(OFS_DST_LAST)) begin
        dst_nxt = {dst_r[23:0], b};
      end
      if (in_l4) begin
        case (l4_ofs[1:0])
          2'd0: begin
            ports_nxt[31:24] = b;
            icmp_nxt[15:8]   = b;
          end
          2'd1: begin
            ports_nxt[23:16] = b;
            icmp_nxt[7:0]    = b;
          end
          2'd2: ports_nxt[15:8] = b;
          2'd3: ports_nxt[7:0] = b;
          default: ports_nxt = ports_r;
        endcase
      end
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  // Where the transport header begins; a length nibble arriving now counts at once.
  // The EtherType is already settled once the transport header can begin.
  always_comb begin
    words_now = (pos == COUNT_BITS'(OFS_IHL)) ? b[3:0] : words_r;
    if (type_r == ETH_TYPE_IPV6) begin
      l4_start_small = 7'(OFS_V6_L4);
    end else begin
      l4_start_small = 7'(ETH_LEN) + {1'b0, words_now, 2'b00};
    end
    l4_start = COUNT_BITS'(l4_start_small);
    l4_ofs   = pos - l4_start;
    in_l4    = (pos >= COUNT_BITS'(ETH_LEN)) && (pos >= l4_start) &&
               (l4_ofs < COUNT_BITS'(4));
  end

  // Frame record handed to the queue on the last beat.
  always_comb begin
    rec_push         = beat_take && beat.last_byte;
    rec.frame_len    = LEN_BITS'(cnt_nxt);
    rec.eth_type     = type_nxt;
    rec.header_words = words_nxt;
    rec.proto        = proto_nxt;
    rec.hops         = hops_nxt;
    rec.src_addr     = src_nxt;
    rec.dst_addr     = dst_nxt;
    rec.port_pair    = ports_nxt;
    rec.icmp_pair    = icmp_nxt;
  end

  // Frame state; everything clears after the last beat.
  always_ff @(posedge clk) begin
    if (!rst_n || rec_push) begin
      cnt_r   <= '0;
      type_r  <= '0;
      words_r <= '0;
      proto_r <= '0;
      hops_r  <= '0;
      src_r   <= '0;
      dst_r   <= '0;
      ports_r <= '0;
      icmp_r  <= '0;
    end else if (beat_take) begin
      cnt_r   <= cnt_nxt;
      type_r  <= type_nxt;
      words_r <= words_nxt;
      proto_r <= proto_nxt;
      hops_r  <= hops_nxt;
      src_r   <= src_nxt;
      dst_r   <= dst_nxt;
      ports_r <= ports_nxt;
      icmp_r  <= icmp_nxt;
    end
  end

endmodule

@@ sv/l2l4hp_queue.sv @@
module l2l4hp_queue #(
  parameter int DEPTH = l2l4hp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  l2l4hp_pkg::q_ctrl_t  ctrl,
  input  l2l4hp_pkg::raw_rec_t wr_rec,
  output l2l4hp_pkg::q_stat_t  stat,
  output l2l4hp_pkg::raw_rec_t rd_rec
);
  import l2l4hp_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  raw_rec_t        slot_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = ctrl.push && !stat.full;
  assign do_pop     = ctrl.pop && !stat.empty;
  assign rd_rec     = slot_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Record storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_rec;
    end
  end

endmodule

@@ sv/l2l4hp_back.sv @@
module l2l4hp_back #(
  parameter int ICMP_HEADER_BYTES = l2l4hp_pkg::ICMP_HEADER_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  l2l4hp_pkg::raw_rec_t rec,
  input  logic                 rec_avail,
  output logic                 rec_take,
  input  logic                 res_pop,
  output logic                 res_empty,
  output l2l4hp_pkg::hdr_out_t res
);
  import l2l4hp_pkg::*;

  hdr_out_t              res_r, res_nxt;
  logic                  valid_r, valid_nxt;
  logic [LEN_BITS-1:0]   rest;
  logic [LEN_BITS-1:0]   trem;
  logic [LEN_BITS-1:0]   hdr_len;
  logic                  eth_ok, v4_ok, v6_ok, l3_ok;
  logic [7:0]            icmp_proto;
  logic [1:0]            icmp_code;

  // Layer checks against the captured length.
  always_comb begin
    eth_ok     = rec.frame_len >= LEN_BITS'(ETH_LEN);
    rest       = rec.frame_len - LEN_BITS'(ETH_LEN);
    hdr_len    = LEN_BITS'({rec.header_words, 2'b00});
    v4_ok      = (rec.eth_type == ETH_TYPE_IPV4) && (rest >= LEN_BITS'(IPV4_MIN_LEN)) &&
                 (rest >= hdr_len);
    v6_ok      = (rec.eth_type == ETH_TYPE_IPV6) && (rest >= LEN_BITS'(IPV6_LEN));
    l3_ok      = eth_ok && (v4_ok || v6_ok);
    trem       = v6_ok ? (rest - LEN_BITS'(IPV6_LEN)) : (rest - hdr_len);
    icmp_proto = v6_ok ? PROTO_ICMPV6 : PROTO_ICMPV4;
    icmp_code  = v6_ok ? ICMP_V6 : ICMP_V4;
  end

  // Build the result record.
  always_comb begin
    res_nxt = '0;
    if (eth_ok) begin
      res_nxt.eth_type = rec.eth_type;
    end
    if (l3_ok) begin
      res_nxt.l3_kind       = v6_ok ? L3_IPV6 : L3_IPV4;
      res_nxt.next_protocol = rec.proto;
      res_nxt.hop_limit     = rec.hops;
      if (!v6_ok) begin
        res_nxt.source_ipv4 = rec.src_addr;
        res_nxt.dest_ipv4   = rec.dst_addr;
      end
      if ((rec.proto == PROTO_TCP && trem >= LEN_BITS'(TCP_LEN)) ||
          (rec.proto == PROTO_UDP && trem >= LEN_BITS'(UDP_LEN))) begin
        res_nxt.has_ports   = 1'b1;
        res_nxt.source_port = rec.port_pair[31:16];
        res_nxt.dest_port   = rec.port_pair[15:0];
      end
      if (rec.proto == icmp_proto && trem >= LEN_BITS'(ICMP_HEADER_BYTES)) begin
        res_nxt.icmp_kind     = icmp_code;
        res_nxt.icmp_msg_type = rec.icmp_pair[15:8];
        res_nxt.icmp_msg_code = rec.icmp_pair[7:0];
      end
    end
  end

  // Output register: refill when empty or when the held result leaves.
  always_comb begin
    rec_take  = rec_avail && (!valid_r || res_pop);
    valid_nxt = valid_r;
    if (rec_take) begin
      valid_nxt = 1'b1;
    end else if (res_pop) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_take) begin
      res_r <= res_nxt;
    end
  end

  assign res_empty = !valid_r;
  assign res       = res_r;

endmodule

@@ sv/l2l4hp_checker.sv @@
module l2l4hp_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_push,
  input logic                 in_full,
  input l2l4hp_pkg::hdr_in_t  in_data,
  input logic                 out_empty,
  input logic                 out_pop,
  input l2l4hp_pkg::hdr_out_t out_data
);
  import l2l4hp_pkg::*;

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result shown right after reset");

  // A result that is not taken stays put.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("waiting result changed or vanished");

  // Without a network layer, no deeper layer is reported.
  a_no_l3: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.l3_kind == L3_NONE) |->
      (!out_data.has_ports && out_data.icmp_kind == ICMP_NONE &&
       out_data.next_protocol == 8'd0 && out_data.hop_limit == 8'd0))
    else $error("transport fields without a network layer");

  // ICMP flavor follows the network layer; addresses only for IPv4.
  a_icmp_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.icmp_kind != ICMP_NONE) |->
      (out_data.icmp_kind == out_data.l3_kind))
    else $error("ICMP kind disagrees with network layer");

  a_ipv4_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.l3_kind != L3_IPV4) |->
      (out_data.source_ipv4 == 32'd0 && out_data.dest_ipv4 == 32'd0))
    else $error("IPv4 address outside an IPv4 record");

endmodule

bind l2_l4_packet_header_parser l2l4hp_checker u_checker (.*);

@@ verif/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import l2l4hp_pkg::*;

  localparam int COUNT_MAX     = (1 << COUNT_BITS_DEF) - 1;
  localparam int CYCLE_LIMIT   = 40_000;
  localparam int RAND_BYTES    = 1100;
  localparam int RAND_FRAMES   = 16;
  localparam int IDLE_PCT      = 15;
  localparam int STALL_CYCLES  = 400;
  localparam int CALM_CYCLES   = 1200;
  localparam int SETTLE_CYCLES = 10;
  localparam int PRINT_CAP     = 40;

  // One directed frame: header selectors, length, and an optional record
  // that can be read off directly (every field zero but the EtherType).
  typedef struct packed {
    logic [15:0] etype;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    logic [31:0] len;
    logic        fixed;
    logic [15:0] fixed_type;
  } dir_row_t;

  // One queued input beat, with the typed record if its frame has one.
  typedef struct packed {
    hdr_in_t  beat;
    logic     fixed;
    hdr_out_t rec;
  } byte_slot_t;

  logic     clk;
  logic     rst_n;
  logic     in_push;
  logic     in_full;
  hdr_in_t  in_data;
  logic     out_empty;
  logic     out_pop;
  hdr_out_t out_data;

  byte_slot_t byte_q[$];
  hdr_out_t   record_q[$];
  dir_row_t   dir_tab[0:18];

  // Shadow copy of the parser's per-frame state.
  int          frm_count;
  logic [15:0] frm_type;
  logic [3:0]  frm_words;
  logic [7:0]  frm_proto;
  logic [7:0]  frm_hops;
  logic [31:0] frm_src;
  logic [31:0] frm_dst;
  logic [31:0] frm_ports;
  logic [15:0] frm_icmp;

  int  err_count;
  int  cycle_count;
  int  frames_queued;
  int  bytes_queued;
  int  records_seen;
  int  full_stalls;
  bit  random_phase;
  bit  rx_hold;
  bit  calm;

  l2_l4_packet_header_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= PRINT_CAP) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
  endtask

  task automatic clear_frame();
    frm_count = 0;
    frm_type  = '0;
    frm_words = '0;
    frm_proto = '0;
    frm_hops  = '0;
    frm_src   = '0;
    frm_dst   = '0;
    frm_ports = '0;
    frm_icmp  = '0;
  endtask

  // Advance the shadow parser by one byte; on the last byte build the record.
  task automatic parse_byte(input hdr_in_t bt, output bit done, output hdr_out_t rec);
    int         pos;
    int         words;
    int         t;
    int         rest;
    int         trem;
    int         hl;
    bit         l3;
    bit         ports;
    logic [7:0] icmp_proto;
    logic [1:0] icmp_code_kind;
    logic [7:0] b;
    pos = frm_count;
    words = int'(frm_words);
    b = bt.data_byte;
    done = 1'b0;
    rec = '0;
    if (pos < COUNT_MAX) begin
      if (pos == OFS_TYPE_HI) frm_type[15:8] = b;
      if (pos == OFS_TYPE_LO) frm_type[7:0] = b;
      if (pos == OFS_IHL) begin
        frm_words = b[3:0];
        words = int'(frm_words);
      end
      if (frm_type == ETH_TYPE_IPV4) begin
        if (pos == OFS_V4_TTL) frm_hops = b;
        if (pos == OFS_V4_PROTO) frm_proto = b;
      end else if (frm_type == ETH_TYPE_IPV6) begin
        if (pos == OFS_V6_NEXT) frm_proto = b;
        if (pos == OFS_V6_HOPS) frm_hops = b;
      end
      if (pos >= OFS_SRC_FIRST && pos <= OFS_SRC_LAST) frm_src = {frm_src[23:0], b};
      if (pos >= OFS_DST_FIRST && pos <= OFS_DST_LAST) frm_dst = {frm_dst[23:0], b};
      // The transport start follows the header length latched so far.
      if (pos >= ETH_LEN) begin
        t = (frm_type == ETH_TYPE_IPV6) ? OFS_V6_L4 : ETH_LEN + 4 * words;
        if (pos >= t && pos - t < 4) begin
          frm_ports[8 * (3 - (pos - t)) +: 8] = b;
          if (pos - t < 2) frm_icmp[8 * (1 - (pos - t)) +: 8] = b;
        end
      end
      frm_count = pos + 1;
    end
    if (bt.last_byte) begin
      done = 1'b1;
      l3 = 1'b0;
      trem = 0;
      icmp_proto = '0;
      icmp_code_kind = ICMP_NONE;
      if (frm_count >= ETH_LEN) begin
        rest = frm_count - ETH_LEN;
        rec.eth_type = frm_type;
        if (frm_type == ETH_TYPE_IPV4) begin
          hl = 4 * int'(frm_words);
          if (rest >= IPV4_MIN_LEN && rest >= hl) begin
            l3 = 1'b1;
            rec.l3_kind = L3_IPV4;
            rec.source_ipv4 = frm_src;
            rec.dest_ipv4 = frm_dst;
            trem = rest - hl;
            icmp_proto = PROTO_ICMPV4;
            icmp_code_kind = ICMP_V4;
          end
        end else if (frm_type == ETH_TYPE_IPV6) begin
          if (rest >= IPV6_LEN) begin
            l3 = 1'b1;
            rec.l3_kind = L3_IPV6;
            trem = rest - IPV6_LEN;
            icmp_proto = PROTO_ICMPV6;
            icmp_code_kind = ICMP_V6;
          end
        end
        if (l3) begin
          rec.next_protocol = frm_proto;
          rec.hop_limit = frm_hops;
          ports = (frm_proto == PROTO_TCP && trem >= TCP_LEN) ||
                  (frm_proto == PROTO_UDP && trem >= UDP_LEN);
          if (ports) begin
            rec.has_ports = 1'b1;
            rec.source_port = frm_ports[31:16];
            rec.dest_port = frm_ports[15:0];
          end
          if (frm_proto == icmp_proto && trem >= ICMP_HEADER_BYTES_DEF) begin
            rec.icmp_kind = icmp_code_kind;
            rec.icmp_msg_type = frm_icmp[15:8];
            rec.icmp_msg_code = frm_icmp[7:0];
          end
        end
      end
      clear_frame();
    end
  endtask

  // Queue one frame of random content with the chosen header bytes in place.
  task automatic queue_frame(input logic [15:0] et, input logic [3:0] ihl,
                             input logic [7:0] proto, input int len,
                             input bit fixed, input logic [15:0] fixed_type);
    byte_slot_t s;
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(255));
      case (i)
        OFS_TYPE_HI:  b = et[15:8];
        OFS_TYPE_LO:  b = et[7:0];
        OFS_IHL:      b = (et == ETH_TYPE_IPV6) ? {4'h6, b[3:0]} : {4'h4, ihl};
        OFS_V6_NEXT:  if (et == ETH_TYPE_IPV6) b = proto;
        OFS_V4_PROTO: if (et == ETH_TYPE_IPV4) b = proto;
        default: ;
      endcase
      s = '0;
      s.beat.data_byte = b;
      s.beat.last_byte = (i == len - 1);
      s.fixed = fixed && (i == len - 1);
      s.rec.eth_type = fixed_type;
      byte_q.push_back(s);
    end
    bytes_queued += len;
    frames_queued++;
  endtask

  // Sender: offer queued beats, hold each until taken, and predict on accept.
  always @(posedge clk) begin : tx_side
    bit       take;
    bit       done;
    hdr_out_t rec;
    if (rst_n) begin
      take = in_push && !in_full;
      if (in_push && in_full) full_stalls++;
      if (take) begin
        parse_byte(in_data, done, rec);
        if (done) begin
          if (byte_q[0].fixed) record_q.push_back(byte_q[0].rec);
          else record_q.push_back(rec);
        end
        void'(byte_q.pop_front());
      end
      if (in_push && !take) begin
        // The offered beat stays on the port until it is taken.
      end else if (byte_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        in_push <= 1'b1;
        in_data <= byte_q[0].beat;
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // Receiver: check each popped record against the oldest expectation.
  always @(posedge clk) begin : rx_side
    hdr_out_t got;
    hdr_out_t want;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        got = out_data;
        if (record_q.size() == 0) begin
          report_mismatch($sformatf("record %0d arrived with none expected", records_seen));
        end else begin
          want = record_q.pop_front();
          if (got.eth_type !== want.eth_type)
            report_mismatch($sformatf("record %0d eth_type %h, want %h",
                                      records_seen, got.eth_type, want.eth_type));
          if (got.l3_kind !== want.l3_kind)
            report_mismatch($sformatf("record %0d l3_kind %h, want %h",
                                      records_seen, got.l3_kind, want.l3_kind));
          if (got.next_protocol !== want.next_protocol)
            report_mismatch($sformatf("record %0d next_protocol %h, want %h",
                                      records_seen, got.next_protocol, want.next_protocol));
          if (got.hop_limit !== want.hop_limit)
            report_mismatch($sformatf("record %0d hop_limit %h, want %h",
                                      records_seen, got.hop_limit, want.hop_limit));
          if (got.source_ipv4 !== want.source_ipv4)
            report_mismatch($sformatf("record %0d source_ipv4 %h, want %h",
                                      records_seen, got.source_ipv4, want.source_ipv4));
          if (got.dest_ipv4 !== want.dest_ipv4)
            report_mismatch($sformatf("record %0d dest_ipv4 %h, want %h",
                                      records_seen, got.dest_ipv4, want.dest_ipv4));
          if (got.has_ports !== want.has_ports)
            report_mismatch($sformatf("record %0d has_ports %b, want %b",
                                      records_seen, got.has_ports, want.has_ports));
          if (got.source_port !== want.source_port)
            report_mismatch($sformatf("record %0d source_port %h, want %h",
                                      records_seen, got.source_port, want.source_port));
          if (got.dest_port !== want.dest_port)
            report_mismatch($sformatf("record %0d dest_port %h, want %h",
                                      records_seen, got.dest_port, want.dest_port));
          if (got.icmp_kind !== want.icmp_kind)
            report_mismatch($sformatf("record %0d icmp_kind %h, want %h",
                                      records_seen, got.icmp_kind, want.icmp_kind));
          if (got.icmp_msg_type !== want.icmp_msg_type)
            report_mismatch($sformatf("record %0d icmp_msg_type %h, want %h",
                                      records_seen, got.icmp_msg_type, want.icmp_msg_type));
          if (got.icmp_msg_code !== want.icmp_msg_code)
            report_mismatch($sformatf("record %0d icmp_msg_code %h, want %h",
                                      records_seen, got.icmp_msg_code, want.icmp_msg_code));
        end
        records_seen++;
      end
      out_pop <= !rx_hold && (calm || $urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver stall long enough to fill the record queue, then a calm stretch.
  initial begin
    rx_hold = 1'b0;
    calm = 1'b0;
    while (!random_phase) @(negedge clk);
    repeat (40) @(negedge clk);
    rx_hold = 1'b1;
    repeat (STALL_CYCLES) @(negedge clk);
    rx_hold = 1'b0;
    repeat (300) @(negedge clk);
    calm = 1'b1;
    repeat (CALM_CYCLES) @(negedge clk);
    calm = 1'b0;
  end

  initial begin : stimulus
    int         r;
    int         p;
    int         ihl_i;
    int         need;
    int         len;
    int         rand_bytes;
    int         rand_frames;
    logic [15:0] et;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_data = '0;
    out_pop = 1'b0;
    err_count = 0;
    cycle_count = 0;
    frames_queued = 0;
    bytes_queued = 0;
    records_seen = 0;
    full_stalls = 0;
    random_phase = 1'b0;
    clear_frame();

    // Directed frames: runts, bare Ethernet, each layer just fitting or just
    // short, short and maximal IPv4 header lengths, and unknown types.
    dir_tab = '{
      '{ETH_TYPE_IPV4, 4'd5,  PROTO_TCP,    32'd1,     1'b1, 16'h0000},
      '{ETH_TYPE_IPV4, 4'd5,  PROTO_TCP,    32'd13,    1'b1, 16'h0000},
      '{16'h1234,      4'd5,  PROTO_TCP,    32'd14,    1'b1, 16'h1234},
      '{16'hFFFF,      4'd15, PROTO_UDP,    32'd14,    1'b1, 16'hFFFF},
      '{16'h0000,      4'd0,  PROTO_UDP,    32'd14,    1'b1, 16'h0000},
      '{ETH_TYPE_IPV4, 4'd5,  PROTO_TCP,    32'd14,    1'b1, ETH_TYPE_IPV4},
      '{ETH_TYPE_IPV4, 4'd5,  PROTO_TCP,    32'd54,    1'b0, 16'h0000},
      '{ETH_TYPE_IPV4, 4'd5,  PROTO_UDP,    32'd42,    1'b0, 16'h0000},
      '{ETH_TYPE_IPV4, 4'd5,  PROTO_UDP,    32'd41,    1'b0, 16'h0000},
      '{ETH_TYPE_IPV4, 4'd5,  PROTO_ICMPV4, 32'd42,    1'b0, 16'h0000},
      '{ETH_TYPE_IPV4, 4'd15, PROTO_TCP,    32'd94,    1'b0, 16'h0000},
      '{ETH_TYPE_IPV4, 4'd0,  PROTO_UDP,    32'd40,    1'b0, 16'h0000},
      '{ETH_TYPE_IPV4, 4'd3,  PROTO_TCP,    32'd60,    1'b0, 16'h0000},
      '{ETH_TYPE_IPV4, 4'd5,  8'hFF,        32'd60,    1'b0, 16'h0000},
      '{ETH_TYPE_IPV4, 4'd5,  PROTO_TCP,    32'd33,    1'b0, 16'h0000},
      '{ETH_TYPE_IPV6, 4'd0,  PROTO_TCP,    32'd74,    1'b0, 16'h0000},
      '{ETH_TYPE_IPV6, 4'd0,  PROTO_UDP,    32'd62,    1'b0, 16'h0000},
      '{ETH_TYPE_IPV6, 4'd0,  PROTO_ICMPV6, 32'd62,    1'b0, 16'h0000},
      '{ETH_TYPE_IPV6, 4'd0,  PROTO_TCP,    32'd1,     1'b1, 16'h0000}
    };
    foreach (dir_tab[i]) begin
      queue_frame(dir_tab[i].etype, dir_tab[i].ihl, dir_tab[i].proto,
                  int'(dir_tab[i].len), dir_tab[i].fixed, dir_tab[i].fixed_type);
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // The sender pauses here until every directed record has been checked.
    while (byte_q.size() != 0 || record_q.size() != 0) @(negedge clk);
    random_phase = 1'b1;

    // Random frames: mostly well-formed IPv4 and IPv6 headers with random
    // content, lengths near each layer's limit, plus runts and odd types.
    rand_bytes = 0;
    rand_frames = 0;
    while (rand_bytes < RAND_BYTES || rand_frames < RAND_FRAMES) begin
      r = $urandom_range(99);
      p = $urandom_range(9);
      case (p)
        0, 1, 2: proto = PROTO_TCP;
        3, 4, 5: proto = PROTO_UDP;
        6:       proto = PROTO_ICMPV4;
        7:       proto = PROTO_ICMPV6;
        default: proto = 8'($urandom_range(255));
      endcase
      need = (proto == PROTO_TCP) ? TCP_LEN :
             (proto == PROTO_UDP) ? UDP_LEN : ICMP_HEADER_BYTES_DEF;
      ihl = 4'd5;
      if (r < 10) begin
        et = 16'($urandom_range(65535));
        len = $urandom_range(20, 1);
      end else if (r < 50) begin
        et = ETH_TYPE_IPV4;
        if ($urandom_range(3) == 0) ihl = 4'($urandom_range(15));
        ihl_i = 4 * int'(ihl);
        len = ETH_LEN + ((ihl_i + need > IPV4_MIN_LEN) ? ihl_i + need : IPV4_MIN_LEN);
      end else if (r < 85) begin
        et = ETH_TYPE_IPV6;
        len = OFS_V6_L4 + need;
      end else begin
        et = 16'($urandom_range(65535));
        ihl = 4'($urandom_range(15));
        len = ETH_LEN + $urandom_range(40);
      end
      if (r >= 10) begin
        len = len + $urandom_range(4) - $urandom_range(4);
        if ($urandom_range(3) == 0) len = len + $urandom_range(30);
      end
      if (len < 1) len = 1;
      queue_frame(et, ihl, proto, len, 1'b0, 16'h0000);
      rand_bytes += len;
      rand_frames++;
    end

    // Drain, then let the pipeline settle so a stray record would show up.
    while (byte_q.size() != 0 || record_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Run covered %0d frames in %0d bytes and checked %0d records,",
             frames_queued, bytes_queued, records_seen);
    $display("including runts and layer edges; input held off by full on %0d cycles.",
             full_stalls);
    if (err_count == 0 && record_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
